// ===== hdl/ntm_pkg.sv =====
// Shared types and constants for the nametable mapper with scanline interrupt.
// Holds the channel word types, the memory write request, bus kinds and register addresses.
// No dependencies.
package ntm_pkg;

	// Memory geometry: both memories are indexed by the low ten address bits.
	localparam int EXRAM_DEPTH = 1024;
	localparam int TABLE_PAGE  = 1024;
	localparam int OFF_W       = $clog2(TABLE_PAGE);
	localparam int TABLE_PAGES = 2;

	// Bus event kinds.
	localparam logic [2:0] KIND_CPU_TICK   = 3'd0;
	localparam logic [2:0] KIND_CPU_WRITE  = 3'd1;
	localparam logic [2:0] KIND_CPU_READ   = 3'd2;
	localparam logic [2:0] KIND_TBL_READ   = 3'd3;
	localparam logic [2:0] KIND_TBL_WRITE  = 3'd4;
	localparam logic [2:0] KIND_PAT_FETCH  = 3'd5;

	// CPU register addresses.
	localparam logic [15:0] ADDR_EXRAM_MODE = 16'h5104;
	localparam logic [15:0] ADDR_SOURCE_MAP = 16'h5105;
	localparam logic [15:0] ADDR_FILL_TILE  = 16'h5106;
	localparam logic [15:0] ADDR_FILL_PAL   = 16'h5107;
	localparam logic [15:0] ADDR_CHR_HIGH   = 16'h5130;
	localparam logic [15:0] ADDR_IRQ_TARGET = 16'h5203;
	localparam logic [15:0] ADDR_IRQ_STATUS = 16'h5204;
	localparam logic [15:0] ADDR_PROD_LOW   = 16'h5205;
	localparam logic [15:0] ADDR_PROD_HIGH  = 16'h5206;
	localparam logic [15:0] ADDR_EXRAM_BASE = 16'h5c00;

	// Table offsets at and above this one address the attribute area.
	localparam logic [OFF_W-1:0] ATTR_BASE = 10'h3c0;

	// Exram modes and table sources.
	localparam logic [1:0] EXMODE_EXT_ATTR = 2'd1;
	localparam logic [1:0] EXMODE_RAM_RW   = 2'd2;
	localparam logic [1:0] EXMODE_RAM_RO   = 2'd3;
	localparam logic [1:0] SRC_PAGE0       = 2'd0;
	localparam logic [1:0] SRC_PAGE1       = 2'd1;
	localparam logic [1:0] SRC_EXRAM       = 2'd2;
	localparam logic [1:0] SRC_FILL        = 2'd3;

	localparam logic [7:0] SOURCE_MAP_RESET = 8'h50;
	localparam logic [7:0] FACTOR_RESET     = 8'hff;
	localparam logic [1:0] IDLE_LIMIT       = 2'd3;
	localparam logic [1:0] BG_FETCHES       = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] address;
		logic [7:0]  data;
	} in_word_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_request;
		logic       frame_active;
		logic       background_fetch;
		logic [7:0] extended_bank;
	} out_word_t;

	typedef struct packed {
		logic                   ex_we;
		logic [TABLE_PAGES-1:0] tbl_we;
		logic [OFF_W-1:0]       addr;
		logic [7:0]             data;
	} mem_wr_t;

	// Replicates a two-bit palette into all four attribute quadrants.
	function automatic logic [7:0] spread_pal(input logic [1:0] p);
		return {4{p}};
	endfunction

endpackage

// ===== hdl/ntm_mem.sv =====
// Expansion RAM and two-page nametable RAM with registered reads.
// Clears both memories after reset and forwards a same-cycle write to the read port.
// Depends on ntm_pkg.
module ntm_mem import ntm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [OFF_W-1:0]            rd_addr,
	input  mem_wr_t                     wr,
	output logic [7:0]                  ex_rdata,
	output logic [TABLE_PAGES-1:0][7:0] tbl_rdata,
	output logic                        ready
);

	logic [7:0]                  ex_mem [EXRAM_DEPTH];
	logic [TABLE_PAGES-1:0][7:0] tbl_mem [TABLE_PAGE];

	logic             clr_busy_q;
	logic [OFF_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + OFF_W'(1);
			if (clr_addr_q == {OFF_W{1'b1}})
				clr_busy_q <= 1'b0;
		end
	end

	assign ready = !clr_busy_q;

	// Both page lanes share one row so a read fetches the two pages at once.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			ex_mem[clr_addr_q]  <= '0;
			tbl_mem[clr_addr_q] <= '0;
		end else begin
			if (wr.ex_we)
				ex_mem[wr.addr] <= wr.data;
			for (int i = 0; i < TABLE_PAGES; i++) begin
				if (wr.tbl_we[i])
					tbl_mem[wr.addr][i] <= wr.data;
			end
		end
		if (rd_en) begin
			ex_rdata <= (wr.ex_we && wr.addr == rd_addr) ? wr.data : ex_mem[rd_addr];
			for (int i = 0; i < TABLE_PAGES; i++) begin
				tbl_rdata[i] <= (wr.tbl_we[i] && wr.addr == rd_addr) ? wr.data
				                                                     : tbl_mem[rd_addr][i];
			end
		end
	end

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("memory clear restarted without reset");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_busy_q && clr_addr_q == {OFF_W{1'b1}}) |=> !clr_busy_q)
		else $error("memory clear ran past the last row");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(wr.ex_we || (|wr.tbl_we)))
		else $error("write request during memory clear");

endmodule

// ===== hdl/nametable_mapper_scanline_irq.sv =====
// Top level of the nametable mapper with scanline interrupt.
// Holds the control registers, scanline detector and multiplier; uses ntm_mem and ntm_pkg.
//
// Channel   Handshake               Word        Carries
// bus       bus_valid / bus_stall   bus_word    one CPU or PPU bus event (in_word_t)
// res       res_valid / res_stall   res_word    one result per event (out_word_t)
//
// An event is accepted every clock while the result side keeps up. Accepting an
// event issues the memory read and moves the event into the decide stage, which
// decides it against the registered read data and loads the result register.
// After reset the block stalls while both memories are cleared. A stalled result holds
// the decided event, and bus_stall rises only during the clear or while that holds with both stages full.
module nametable_mapper_scanline_irq import ntm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bus_valid,
	output logic      bus_stall,
	input  in_word_t  bus_word,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_word
);

	// Decide stage: the event whose memory read has returned.
	logic     s1_valid_q;
	in_word_t s1_word_q;

	logic      out_valid_q;
	out_word_t out_q;

	logic bus_accept;
	logic adv;
	logic mem_ready;

	logic [7:0]                  ex_rdata;
	logic [TABLE_PAGES-1:0][7:0] tbl_rdata;
	mem_wr_t                     mem_wr;
	mem_wr_t                     wr_d;

	// Architectural state and its next values.
	logic [7:0] source_map_q, source_map_d;
	logic [1:0] exram_mode_q, exram_mode_d;
	logic [7:0] fill_tile_q, fill_tile_d;
	logic [1:0] fill_pal_q, fill_pal_d;
	logic [1:0] chr_high_q, chr_high_d;
	logic [7:0] irq_target_q, irq_target_d;
	logic       irq_en_q, irq_en_d;
	logic       irq_pend_q, irq_pend_d;
	logic       in_frame_q, in_frame_d;
	logic [7:0] line_cnt_q, line_cnt_d;
	logic [4:0] tile_cnt_q, tile_cnt_d;
	logic [1:0] idle_cnt_q, idle_cnt_d;
	logic       ppu_seen_q, ppu_seen_d;
	logic [7:0] fac_a_q, fac_a_d;
	logic [7:0] fac_b_q, fac_b_d;
	logic [7:0] attr_latch_q, attr_latch_d;
	logic [1:0] bg_left_q, bg_left_d;

	out_word_t res_d;

	// The decide stage moves on when the result register is free or being emptied.
	assign adv        = s1_valid_q && (!out_valid_q || !res_stall);
	assign bus_stall  = !mem_ready || (s1_valid_q && !adv);
	assign bus_accept = bus_valid && !bus_stall;

	// Writes only take effect when the deciding event retires.
	assign mem_wr.ex_we  = wr_d.ex_we && adv;
	assign mem_wr.tbl_we = adv ? wr_d.tbl_we : '0;
	assign mem_wr.addr   = wr_d.addr;
	assign mem_wr.data   = wr_d.data;

	ntm_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (bus_accept),
		.rd_addr   (bus_word.address[OFF_W-1:0]),
		.wr        (mem_wr),
		.ex_rdata  (ex_rdata),
		.tbl_rdata (tbl_rdata),
		.ready     (mem_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (bus_accept)
				s1_valid_q <= 1'b1;
			else if (adv)
				s1_valid_q <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bus_accept)
			s1_word_q <= bus_word;
		if (adv)
			out_q <= res_d;
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	// Decode of the event in the decide stage.
	logic [15:0]      addr;
	logic [7:0]       wdat;
	logic [OFF_W-1:0] off;
	logic [1:0]       tbl;
	logic             is_attr;
	logic [1:0]       src;
	logic             in_exram_win;
	logic [15:0]      prod;
	logic [7:0]       line_inc;

	assign addr         = s1_word_q.address;
	assign wdat         = s1_word_q.data;
	assign off          = addr[OFF_W-1:0];
	assign tbl          = addr[OFF_W+1:OFF_W];
	assign is_attr      = off >= ATTR_BASE;
	assign src          = source_map_q[{tbl, 1'b0} +: 2];
	assign in_exram_win = addr[15:OFF_W] == ADDR_EXRAM_BASE[15:OFF_W];
	assign prod         = 16'(fac_a_q) * 16'(fac_b_q);
	assign line_inc     = line_cnt_q + 8'd1;

	always_comb begin
		source_map_d = source_map_q;
		exram_mode_d = exram_mode_q;
		fill_tile_d  = fill_tile_q;
		fill_pal_d   = fill_pal_q;
		chr_high_d   = chr_high_q;
		irq_target_d = irq_target_q;
		irq_en_d     = irq_en_q;
		irq_pend_d   = irq_pend_q;
		in_frame_d   = in_frame_q;
		line_cnt_d   = line_cnt_q;
		tile_cnt_d   = tile_cnt_q;
		idle_cnt_d   = idle_cnt_q;
		ppu_seen_d   = ppu_seen_q;
		fac_a_d      = fac_a_q;
		fac_b_d      = fac_b_q;
		attr_latch_d = attr_latch_q;
		bg_left_d    = bg_left_q;
		wr_d.ex_we   = 1'b0;
		wr_d.tbl_we  = '0;
		wr_d.addr    = off;
		wr_d.data    = wdat;
		res_d        = '0;

		unique case (s1_word_q.kind)
			KIND_CPU_TICK: begin
				// CPU ticks with no PPU activity between them count up to IDLE_LIMIT; reaching it means rendering has stopped.
				if (ppu_seen_q) begin
					idle_cnt_d = '0;
				end else if (idle_cnt_q != IDLE_LIMIT) begin
					idle_cnt_d = idle_cnt_q + 2'd1;
					if (idle_cnt_q == IDLE_LIMIT - 2'd1) begin
						in_frame_d = 1'b0;
						tile_cnt_d = '0;
						bg_left_d  = '0;
					end
				end
				ppu_seen_d = 1'b0;
			end
			KIND_CPU_WRITE: begin
				if (in_exram_win) begin
					wr_d.ex_we = exram_mode_q != EXMODE_RAM_RO;
				end else begin
					unique case (addr)
						ADDR_EXRAM_MODE: exram_mode_d = wdat[1:0];
						ADDR_SOURCE_MAP: source_map_d = wdat;
						ADDR_FILL_TILE:  fill_tile_d  = wdat;
						ADDR_FILL_PAL:   fill_pal_d   = wdat[1:0];
						ADDR_CHR_HIGH:   chr_high_d   = wdat[1:0];
						ADDR_IRQ_TARGET: irq_target_d = wdat;
						ADDR_IRQ_STATUS: begin
							irq_en_d          = wdat[7];
							res_d.irq_request = wdat[7] && irq_pend_q;
						end
						ADDR_PROD_LOW:   fac_a_d = wdat;
						ADDR_PROD_HIGH:  fac_b_d = wdat;
						default: ;
					endcase
				end
			end
			KIND_CPU_READ: begin
				unique case (addr)
					ADDR_IRQ_STATUS: begin
						// Reading status acknowledges the pending interrupt.
						res_d.read_data = {irq_pend_q, in_frame_q, 6'd0};
						irq_pend_d      = 1'b0;
					end
					ADDR_PROD_LOW:  res_d.read_data = prod[7:0];
					ADDR_PROD_HIGH: res_d.read_data = prod[15:8];
					default: begin
						if (in_exram_win && exram_mode_q >= EXMODE_RAM_RW)
							res_d.read_data = ex_rdata;
					end
				endcase
			end
			KIND_TBL_READ: begin
				ppu_seen_d = 1'b1;
				idle_cnt_d = '0;
				if (!is_attr) begin
					// Tile fetch: latch the extended attribute and open two
					// background pattern fetches; the first fetch of a line
					// advances the scanline counter, or opens the frame at line zero.
					attr_latch_d = ex_rdata;
					bg_left_d    = BG_FETCHES;
					if (tile_cnt_q == '0) begin
						if (!in_frame_q) begin
							in_frame_d = 1'b1;
							line_cnt_d = '0;
						end else begin
							line_cnt_d = line_inc;
							if (irq_target_q != '0 && line_inc == irq_target_q) begin
								irq_pend_d        = 1'b1;
								res_d.irq_request = irq_en_q;
							end
						end
					end
					tile_cnt_d = tile_cnt_q + 5'd1;
				end
				if (is_attr && exram_mode_q == EXMODE_EXT_ATTR) begin
					res_d.read_data = spread_pal(attr_latch_q[7:6]);
				end else begin
					case (src)
						SRC_PAGE0: res_d.read_data = tbl_rdata[0];
						SRC_PAGE1: res_d.read_data = tbl_rdata[1];
						SRC_EXRAM: res_d.read_data =
							(exram_mode_q <= EXMODE_EXT_ATTR) ? ex_rdata : 8'd0;
						default:   res_d.read_data =
							is_attr ? spread_pal(fill_pal_q) : fill_tile_q;
					endcase
				end
			end
			KIND_TBL_WRITE: begin
				ppu_seen_d = 1'b1;
				idle_cnt_d = '0;
				case (src)
					SRC_PAGE0: wr_d.tbl_we[0] = 1'b1;
					SRC_PAGE1: wr_d.tbl_we[1] = 1'b1;
					SRC_EXRAM: wr_d.ex_we     = exram_mode_q <= EXMODE_EXT_ATTR;
					default: ;
				endcase
			end
			KIND_PAT_FETCH: begin
				ppu_seen_d = 1'b1;
				idle_cnt_d = '0;
				if (bg_left_q != '0) begin
					bg_left_d              = bg_left_q - 2'd1;
					res_d.background_fetch = 1'b1;
					if (exram_mode_q == EXMODE_EXT_ATTR)
						res_d.extended_bank = {chr_high_q, attr_latch_q[5:0]};
				end
			end
			default: ;
		endcase

		res_d.frame_active = in_frame_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_map_q <= SOURCE_MAP_RESET;
			exram_mode_q <= '0;
			fill_tile_q  <= '0;
			fill_pal_q   <= '0;
			chr_high_q   <= '0;
			irq_target_q <= '0;
			irq_en_q     <= 1'b0;
			irq_pend_q   <= 1'b0;
			in_frame_q   <= 1'b0;
			line_cnt_q   <= '0;
			tile_cnt_q   <= '0;
			idle_cnt_q   <= IDLE_LIMIT;
			ppu_seen_q   <= 1'b0;
			fac_a_q      <= FACTOR_RESET;
			fac_b_q      <= FACTOR_RESET;
			attr_latch_q <= '0;
			bg_left_q    <= '0;
		end else if (adv) begin
			source_map_q <= source_map_d;
			exram_mode_q <= exram_mode_d;
			fill_tile_q  <= fill_tile_d;
			fill_pal_q   <= fill_pal_d;
			chr_high_q   <= chr_high_d;
			irq_target_q <= irq_target_d;
			irq_en_q     <= irq_en_d;
			irq_pend_q   <= irq_pend_d;
			in_frame_q   <= in_frame_d;
			line_cnt_q   <= line_cnt_d;
			tile_cnt_q   <= tile_cnt_d;
			idle_cnt_q   <= idle_cnt_d;
			ppu_seen_q   <= ppu_seen_d;
			fac_a_q      <= fac_a_d;
			fac_b_q      <= fac_b_d;
			attr_latch_q <= attr_latch_d;
			bg_left_q    <= bg_left_d;
		end
	end

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_frame_q) |-> (tile_cnt_q == '0 && bg_left_q == '0))
		else $error("frame ended with tile or background fetch count left over");

	a_bg_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		bg_left_q <= BG_FETCHES)
		else $error("background fetch count out of range");

	a_retire_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid)
		else $error("retired event produced no result");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for nametable_mapper_scanline_irq: CPU and PPU bus words go in, one result word
// comes out per bus word, and each is checked against a shadow copy of the mapper state.
// Depends on ntm_pkg and the block's RTL only.
module testbench;
	import ntm_pkg::*;

	localparam int CLK_PERIOD = 12;

	// Kinds the block leaves alone.
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam logic [15:0] ADDR_EXRAM_LAST = 16'(ADDR_EXRAM_BASE + EXRAM_DEPTH - 1);

	// Length of the long receiver hold-off that fills the block and stalls its input.
	localparam int HOLD_CYCLES = 150;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// One row of the directed table. Where fixed is set, want is the result typed in by
	// hand; otherwise the shadow state decides the result.
	typedef struct packed {
		in_word_t  word;
		logic      fixed;
		out_word_t want;
	} step_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      bus_valid = 1'b0;
	logic      bus_stall;
	in_word_t  bus_word  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_word_t res_word;

	always #(CLK_PERIOD / 2) clk = ~clk;

	nametable_mapper_scanline_irq DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.bus_valid (bus_valid),
		.bus_stall (bus_stall),
		.bus_word  (bus_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	// Results still owed by the block, oldest first.
	out_word_t  due_results[$];
	step_row_t  directed_rows[$];
	int         mismatch_count = 0;
	int         words_sent     = 0;
	idle_mode_t idle_phase     = IDLE_NONE;

	// The main process bumps the token to ask for one long hold-off; the receiver
	// process notices the change and counts the stretch out on its own.
	int pressure_token = 0;
	int pressure_seen  = 0;
	int hold_left      = 0;

	// Shadow copy of everything the mapper keeps.
	logic [7:0] sh_exram [EXRAM_DEPTH];
	logic [7:0] sh_nt [TABLE_PAGES * TABLE_PAGE];
	logic [7:0] sh_srcmap;
	logic [1:0] sh_exmode;
	logic [7:0] sh_fill_tile;
	logic [1:0] sh_fill_pal;
	logic [1:0] sh_chr_hi;
	logic [7:0] sh_irq_line;
	logic       sh_irq_en;
	logic       sh_irq_pend;
	logic       sh_in_frame;
	logic [7:0] sh_line;
	logic [4:0] sh_tiles;
	logic [1:0] sh_idle;
	logic       sh_ppu_seen;
	logic [7:0] sh_fa;
	logic [7:0] sh_fb;
	logic [7:0] sh_attr;
	logic [1:0] sh_bg_left;

	// Applies one bus word to the shadow state and returns the result word it causes.
	function automatic out_word_t decode_bus_event(input in_word_t w);
		out_word_t   r;
		logic [11:0] pa;
		logic [9:0]  off;
		logic [1:0]  src;
		logic [15:0] prod;
		logic        is_attr;
		logic        in_exram;
		r        = '0;
		pa       = w.address[11:0];
		off      = pa[9:0];
		src      = sh_srcmap[{pa[11:10], 1'b0} +: 2];
		is_attr  = off >= ATTR_BASE;
		prod     = 16'(sh_fa) * 16'(sh_fb);
		in_exram = w.address >= ADDR_EXRAM_BASE && w.address <= ADDR_EXRAM_LAST;
		case (w.kind)
		KIND_CPU_TICK: begin
			// CPU ticks in a row with no PPU access count up to IDLE_LIMIT; reaching it means the frame has ended.
			if (sh_ppu_seen) begin
				sh_idle = '0;
			end else if (sh_idle < IDLE_LIMIT) begin
				sh_idle = sh_idle + 2'd1;
				if (sh_idle == IDLE_LIMIT) begin
					sh_in_frame = 1'b0;
					sh_tiles    = '0;
					sh_bg_left  = '0;
				end
			end
			sh_ppu_seen = 1'b0;
		end
		KIND_CPU_WRITE: begin
			if (in_exram) begin
				if (sh_exmode != EXMODE_RAM_RO)
					sh_exram[w.address[9:0]] = w.data;
			end else begin
				case (w.address)
				ADDR_EXRAM_MODE: sh_exmode    = w.data[1:0];
				ADDR_SOURCE_MAP: sh_srcmap    = w.data;
				ADDR_FILL_TILE:  sh_fill_tile = w.data;
				ADDR_FILL_PAL:   sh_fill_pal  = w.data[1:0];
				ADDR_CHR_HIGH:   sh_chr_hi    = w.data[1:0];
				ADDR_IRQ_TARGET: sh_irq_line  = w.data;
				ADDR_IRQ_STATUS: begin
					sh_irq_en     = w.data[7];
					r.irq_request = sh_irq_en & sh_irq_pend;
				end
				ADDR_PROD_LOW:   sh_fa = w.data;
				ADDR_PROD_HIGH:  sh_fb = w.data;
				default: ;
				endcase
			end
		end
		KIND_CPU_READ: begin
			if (w.address == ADDR_IRQ_STATUS) begin
				r.read_data = {sh_irq_pend, sh_in_frame, 6'd0};
				sh_irq_pend = 1'b0;
			end else if (w.address == ADDR_PROD_LOW) begin
				r.read_data = prod[7:0];
			end else if (w.address == ADDR_PROD_HIGH) begin
				r.read_data = prod[15:8];
			end else if (in_exram && sh_exmode >= EXMODE_RAM_RW) begin
				r.read_data = sh_exram[w.address[9:0]];
			end
		end
		KIND_TBL_READ: begin
			sh_ppu_seen = 1'b1;
			sh_idle     = '0;
			if (!is_attr) begin
				// A tile read latches the extended attribute and opens two background
				// pattern fetches; the first tile read of a group of 32 starts a line.
				sh_attr    = sh_exram[off];
				sh_bg_left = BG_FETCHES;
				if (sh_tiles == '0) begin
					if (!sh_in_frame) begin
						sh_in_frame = 1'b1;
						sh_line     = '0;
					end else begin
						sh_line = sh_line + 8'd1;
						if (sh_irq_line != '0 && sh_line == sh_irq_line) begin
							sh_irq_pend   = 1'b1;
							r.irq_request = sh_irq_en;
						end
					end
				end
				sh_tiles = sh_tiles + 5'd1;
			end
			if (is_attr && sh_exmode == EXMODE_EXT_ATTR) begin
				r.read_data = {4{sh_attr[7:6]}};
			end else begin
				case (src)
				SRC_PAGE0: r.read_data = sh_nt[{1'b0, off}];
				SRC_PAGE1: r.read_data = sh_nt[{1'b1, off}];
				SRC_EXRAM: r.read_data = sh_exmode <= EXMODE_EXT_ATTR ? sh_exram[off] : 8'h00;
				default:   r.read_data = is_attr ? {4{sh_fill_pal}} : sh_fill_tile;
				endcase
			end
		end
		KIND_TBL_WRITE: begin
			sh_ppu_seen = 1'b1;
			sh_idle     = '0;
			case (src)
			SRC_PAGE0: sh_nt[{1'b0, off}] = w.data;
			SRC_PAGE1: sh_nt[{1'b1, off}] = w.data;
			SRC_EXRAM: begin
				if (sh_exmode <= EXMODE_EXT_ATTR)
					sh_exram[off] = w.data;
			end
			default: ;
			endcase
		end
		KIND_PAT_FETCH: begin
			sh_ppu_seen = 1'b1;
			sh_idle     = '0;
			if (sh_bg_left != '0) begin
				sh_bg_left         = sh_bg_left - 2'd1;
				r.background_fetch = 1'b1;
				if (sh_exmode == EXMODE_EXT_ATTR)
					r.extended_bank = {sh_chr_hi, sh_attr[5:0]};
			end
		end
		default: ;
		endcase
		r.frame_active = sh_in_frame;
		return r;
	endfunction

	// Decides whether a side sits out this cycle, from the current idling phase.
	function automatic bit idle_roll(input bit rx_side);
		int roll;
		roll = $urandom_range(99);
		case (idle_phase)
		IDLE_SENDER:   return !rx_side && roll < 82;
		IDLE_RECEIVER: return rx_side && roll < 82;
		IDLE_BOTH:     return roll < 23;
		default:       return 1'b0;
		endcase
	endfunction

	// Offers one bus word and waits until it is taken. The shadow state is advanced at
	// the edge that accepts the word, so expectations line up with acceptance order.
	task automatic send_word(input in_word_t w, input logic fixed, input out_word_t want);
		out_word_t predicted;
		while (idle_roll(1'b0)) begin
			bus_valid <= 1'b0;
			@(posedge clk);
		end
		bus_valid <= 1'b1;
		bus_word  <= w;
		@(posedge clk);
		while (bus_stall) @(posedge clk);
		predicted = decode_bus_event(w);
		due_results.push_back(fixed ? want : predicted);
		words_sent++;
	endtask

	task automatic add_row(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
		input logic fixed, input logic [7:0] rd, input logic fr);
		step_row_t row;
		row                    = '0;
		row.word               = {k, a, d};
		row.fixed              = fixed;
		row.want.read_data     = rd;
		row.want.frame_active  = fr;
		directed_rows.push_back(row);
	endtask

	// Random traffic. Most of it is shaped like real frames: runs of tile reads, each
	// followed at times by an attribute read and then by its pattern fetches, with register
	// writes and status reads between them and CPU ticks that may close the frame.
	// The rest is plain noise over all kinds, addresses and data.
	task automatic run_bus_traffic(input int count);
		int          stop;
		int          n;
		in_word_t    w;
		logic [15:0] a;
		stop = words_sent + count;
		while (words_sent < stop) begin
			a = 16'($urandom);
			w = {KIND_CPU_WRITE, a, 8'($urandom)};
			case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(9))
				0: w.address = ADDR_EXRAM_MODE;
				1: w.address = ADDR_SOURCE_MAP;
				2: w.address = ADDR_FILL_TILE;
				3: w.address = ADDR_FILL_PAL;
				4: w.address = ADDR_CHR_HIGH;
				5: begin
					// Low target lines are reached within a short frame.
					w.address = ADDR_IRQ_TARGET;
					if ($urandom_range(3) != 0)
						w.data = 8'($urandom_range(5));
				end
				6: w.address = ADDR_IRQ_STATUS;
				7: w.address = ADDR_PROD_LOW;
				8: w.address = ADDR_PROD_HIGH;
				default: w.address = ADDR_EXRAM_BASE | {6'd0, a[9:0]};
				endcase
				send_word(w, 1'b0, '0);
			end
			2: begin
				w.kind = KIND_CPU_READ;
				case ($urandom_range(3))
				0: w.address = ADDR_IRQ_STATUS;
				1: w.address = ADDR_PROD_LOW;
				2: w.address = ADDR_PROD_HIGH;
				default: w.address = ADDR_EXRAM_BASE | {6'd0, a[9:0]};
				endcase
				send_word(w, 1'b0, '0);
			end
			3, 4, 5, 6: begin
				repeat ($urandom_range(8, 40)) begin
					a       = 16'($urandom);
					a[9:0]  = 10'($urandom_range(959));
					send_word({KIND_TBL_READ, a, 8'($urandom)}, 1'b0, '0);
					if ($urandom_range(1) == 0) begin
						a[9:0] = 10'($urandom_range(1023, 960));
						send_word({KIND_TBL_READ, a, 8'($urandom)}, 1'b0, '0);
					end
					n = $urandom_range(3) == 0 ? $urandom_range(3) : 2;
					repeat (n)
						send_word({KIND_PAT_FETCH, 16'($urandom), 8'($urandom)}, 1'b0, '0);
					if ($urandom_range(3) == 0)
						send_word({KIND_CPU_TICK, 16'($urandom), 8'($urandom)}, 1'b0, '0);
				end
			end
			7: begin
				repeat ($urandom_range(1, 5))
					send_word({KIND_CPU_TICK, 16'($urandom), 8'($urandom)}, 1'b0, '0);
			end
			8: begin
				if ($urandom_range(1) == 0)
					w.kind = KIND_TBL_WRITE;
				else
					w.address = ADDR_EXRAM_BASE | {6'd0, a[9:0]};
				send_word(w, 1'b0, '0);
			end
			default: begin
				send_word({3'($urandom_range(7)), 16'($urandom), 8'($urandom)}, 1'b0, '0);
			end
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Receiver: takes result words, compares them against the oldest expectation and
	// drives res_stall for the next cycle, including the long hold-off when asked.
	always @(posedge clk) begin
		out_word_t head;
		if (res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result word with nothing expected, got %0h", $time, res_word);
			end else begin
				head = due_results.pop_front();
				check_field("read_data", head.read_data, res_word.read_data);
				check_field("irq_request", {7'd0, head.irq_request},
					{7'd0, res_word.irq_request});
				check_field("frame_active", {7'd0, head.frame_active},
					{7'd0, res_word.frame_active});
				check_field("background_fetch", {7'd0, head.background_fetch},
					{7'd0, res_word.background_fetch});
				check_field("extended_bank", head.extended_bank, res_word.extended_bank);
			end
		end
		if (pressure_token != pressure_seen) begin
			pressure_seen = pressure_token;
			hold_left     = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= idle_roll(1'b1);
		end
	end

	initial begin
		for (int i = 0; i < EXRAM_DEPTH; i++)
			sh_exram[i] = '0;
		for (int i = 0; i < TABLE_PAGES * TABLE_PAGE; i++)
			sh_nt[i] = '0;
		sh_srcmap    = SOURCE_MAP_RESET;
		sh_exmode    = '0;
		sh_fill_tile = '0;
		sh_fill_pal  = '0;
		sh_chr_hi    = '0;
		sh_irq_line  = '0;
		sh_irq_en    = 1'b0;
		sh_irq_pend  = 1'b0;
		sh_in_frame  = 1'b0;
		sh_line      = '0;
		sh_tiles     = '0;
		sh_idle      = IDLE_LIMIT;
		sh_ppu_seen  = 1'b0;
		sh_fa        = FACTOR_RESET;
		sh_fb        = FACTOR_RESET;
		sh_attr      = '0;
		sh_bg_left   = '0;

		// Directed table: kind, address, data, typed-in flag, read_data, frame_active.
		// Status and product after reset, then the unused kinds.
		add_row(KIND_CPU_READ,  ADDR_IRQ_STATUS, 8'h00, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_READ,  ADDR_PROD_LOW,   8'h00, 1'b1, 8'h01, 1'b0);
		add_row(KIND_CPU_READ,  ADDR_PROD_HIGH,  8'h00, 1'b1, 8'hfe, 1'b0);
		add_row(KIND_SPARE_HI,  16'hffff,        8'hff, 1'b1, 8'h00, 1'b0);
		add_row(KIND_SPARE_LO,  16'h0000,        8'h00, 1'b1, 8'h00, 1'b0);
		// A zero factor, then unmapped CPU addresses at both ends of the bus.
		add_row(KIND_CPU_WRITE, ADDR_PROD_LOW,   8'h00, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_READ,  ADDR_PROD_HIGH,  8'h00, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_WRITE, 16'hffff,        8'hff, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_READ,  16'h0000,        8'h00, 1'b1, 8'h00, 1'b0);
		// Exram mode 3 drops CPU writes to the expansion RAM but still reads it.
		add_row(KIND_CPU_WRITE, ADDR_EXRAM_MODE, 8'hff, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_WRITE, ADDR_EXRAM_LAST, 8'ha5, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_READ,  ADDR_EXRAM_LAST, 8'h00, 1'b1, 8'h00, 1'b0);
		// Mode 2 makes the expansion RAM writable and readable.
		add_row(KIND_CPU_WRITE, ADDR_EXRAM_MODE, 8'h02, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_WRITE, ADDR_EXRAM_BASE, 8'hff, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_READ,  ADDR_EXRAM_BASE, 8'h00, 1'b1, 8'hff, 1'b0);
		// Every table maps to the fill tile and attribute.
		add_row(KIND_CPU_WRITE, ADDR_SOURCE_MAP, 8'hff, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_WRITE, ADDR_FILL_TILE,  8'h3c, 1'b1, 8'h00, 1'b0);
		add_row(KIND_CPU_WRITE, ADDR_FILL_PAL,   8'hff, 1'b1, 8'h00, 1'b0);
		// PPU side: high address bits are ignored, the first tile read opens the frame,
		// and a write to a fill table goes nowhere.
		add_row(KIND_TBL_READ,  16'hffff,        8'h00, 1'b0, 8'h00, 1'b0);
		add_row(KIND_TBL_READ,  16'h0000,        8'hff, 1'b0, 8'h00, 1'b0);
		add_row(KIND_PAT_FETCH, 16'hffff,        8'hff, 1'b0, 8'h00, 1'b0);
		add_row(KIND_TBL_WRITE, 16'h0fff,        8'hff, 1'b0, 8'h00, 1'b0);
		add_row(KIND_CPU_WRITE, ADDR_IRQ_TARGET, 8'hff, 1'b1, 8'h00, 1'b1);
		add_row(KIND_CPU_WRITE, ADDR_CHR_HIGH,   8'hff, 1'b1, 8'h00, 1'b1);
		add_row(KIND_CPU_WRITE, ADDR_IRQ_STATUS, 8'h80, 1'b1, 8'h00, 1'b1);
		add_row(KIND_CPU_TICK,  16'h0000,        8'h00, 1'b0, 8'h00, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its memories after reset and stalls meanwhile; the handshake
		// in send_word simply waits that out.
		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);

		run_bus_traffic(150);
		pressure_token++;
		run_bus_traffic(150);
		idle_phase = IDLE_SENDER;
		run_bus_traffic(200);
		idle_phase = IDLE_RECEIVER;
		run_bus_traffic(200);
		idle_phase = IDLE_BOTH;
		run_bus_traffic(200);
		idle_phase = IDLE_NONE;
		run_bus_traffic(100);
		bus_valid <= 1'b0;

		// Drain: every expected word must arrive, then a few more cycles show that no
		// stray word follows.
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run including the clearing pass.
	initial begin
		#(CLK_PERIOD * 200000);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
